/* rtl/whbc_pkg.sv */
// Package: types, constants and codes shared by the histogram bincount engine.
package whbc_pkg;

    localparam int NUM_BINS   = 256;
    localparam int ACC_WIDTH  = 48;
    localparam int BIN_AW     = $clog2(NUM_BINS);
    localparam int MAXP_W     = $clog2(NUM_BINS + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [1:0] {
        MODE_ACC   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NEG   = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH  = 2'd0,
        CFG_USE_WEIGHTS = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] sample;
        logic signed [31:0] weight;
        logic [7:0]         read_index;
    } req_t;

    typedef struct packed {
        logic signed [47:0] bin_sum;
        logic [8:0]         bins_used;
        logic [1:0]         status;
    } rsp_t;

endpackage

/* rtl/whbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module whbc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/weighted_histogram_bincount.sv */
// Histogram bincount engine: accumulate, read and clear of weighted bins in a RAM.
// Every transaction on the request channel yields exactly one response, via the p1 stage
// and the response register; one transaction per cycle is sustained without rsp_stall.
// The bin RAM read is issued at acceptance; the add and write-back happen as the p1 stage
// advances, with the write data forwarded when the next transaction hits the same bin.
// Each bin has a valid flop, so reset and the clear mode take effect at once with no sweep
// over the RAM. Configuration writes are taken in every cycle (cfg_ready is always high).
module weighted_histogram_bincount
    import whbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] min_length_reg;
    logic                  use_weights_reg;

    logic                  p1_valid_reg;
    req_t                  p1_data_reg;
    logic                  fwd_hit_reg;
    logic [ACC_WIDTH-1:0]  fwd_data_reg;
    logic                  fwd_hit_next;
    logic [NUM_BINS-1:0]   bin_vld_reg;
    logic [MAXP_W-1:0]     maxp_reg;
    logic [MAXP_W-1:0]     maxp_next;

    logic                  rsp_valid_reg;
    rsp_t                  rsp_data_reg;
    rsp_t                  rsp_data_next;

    logic                  req_accept;
    logic                  p1_go;
    logic [BIN_AW-1:0]     rd_addr;
    logic [BIN_AW-1:0]     p1_addr;
    logic [ACC_WIDTH-1:0]  ram_rdata;
    logic [ACC_WIDTH-1:0]  bin_old;
    logic [ACC_WIDTH-1:0]  bin_inc;
    logic [ACC_WIDTH-1:0]  bin_new;
    logic                  ram_we;
    logic                  s_neg;
    logic                  s_over;
    logic                  acc_ok;
    logic                  rd_over;
    logic [MAXP_W-1:0]     idx_plus_one;

    // handshake
    assign cfg_ready  = 1'b1;
    assign p1_go      = p1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = p1_valid_reg && !p1_go;
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    assign rd_addr = (req_data.mode == MODE_READ) ? BIN_AW'(req_data.read_index)
                                                  : BIN_AW'(req_data.sample);
    assign p1_addr = (p1_data_reg.mode == MODE_READ) ? BIN_AW'(p1_data_reg.read_index)
                                                     : BIN_AW'(p1_data_reg.sample);

    whbc_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p1_addr),
        .wdata (bin_new),
        .re    (req_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s_neg   = p1_data_reg.sample[31];
        s_over  = !s_neg && ($unsigned(p1_data_reg.sample) >= 32'(NUM_BINS));
        rd_over = 32'(p1_data_reg.read_index) >= 32'(NUM_BINS);
        acc_ok  = (p1_data_reg.mode == MODE_ACC) && !s_neg && !s_over;
        ram_we  = p1_go && acc_ok;

        if (fwd_hit_reg)
        begin
            bin_old = fwd_data_reg;
        end
        else if (bin_vld_reg[p1_addr])
        begin
            bin_old = ram_rdata;
        end
        else
        begin
            bin_old = '0;
        end

        bin_inc = use_weights_reg ? ACC_WIDTH'(p1_data_reg.weight) : ACC_WIDTH'(1);
        bin_new = bin_old + bin_inc;

        idx_plus_one = MAXP_W'(p1_addr) + MAXP_W'(1);
        maxp_next    = maxp_reg;
        if (acc_ok && (idx_plus_one > maxp_reg))
        begin
            maxp_next = idx_plus_one;
        end
        else if (p1_data_reg.mode == MODE_CLEAR)
        begin
            maxp_next = '0;
        end

        rsp_data_next.bin_sum   = '0;
        rsp_data_next.status    = STAT_OK;
        rsp_data_next.bins_used = (32'(maxp_next) > 32'(min_length_reg)) ? 9'(maxp_next)
                                                                          : 9'(min_length_reg);
        case (p1_data_reg.mode)
            MODE_ACC:
            begin
                if (s_neg)
                begin
                    rsp_data_next.status = STAT_NEG;
                end
                else if (s_over)
                begin
                    rsp_data_next.status = STAT_RANGE;
                end
            end
            MODE_READ:
            begin
                if (rd_over)
                begin
                    rsp_data_next.status = STAT_RANGE;
                end
                else
                begin
                    rsp_data_next.bin_sum = 48'($signed(bin_old));
                end
            end
            default:
            begin
                rsp_data_next.status = STAT_OK;
            end
        endcase

        // next transaction reads a bin being written right now
        fwd_hit_next = ram_we && (p1_addr == rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg  <= '0;
            use_weights_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MIN_LENGTH)
            begin
                min_length_reg <= cfg_data;
            end
            else if (cfg_index == CFG_USE_WEIGHTS)
            begin
                use_weights_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            bin_vld_reg   <= '0;
            maxp_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                p1_valid_reg <= 1'b1;
                fwd_hit_reg  <= fwd_hit_next;
            end
            else if (p1_go)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (p1_go)
            begin
                maxp_reg <= maxp_next;
                if (p1_data_reg.mode == MODE_CLEAR)
                begin
                    bin_vld_reg <= '0;
                end
                else if (ram_we)
                begin
                    bin_vld_reg[p1_addr] <= 1'b1;
                end
            end

            if (p1_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            p1_data_reg  <= req_data;
            fwd_data_reg <= bin_new;
        end
        if (p1_go)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> p1_valid_reg && rsp_valid_reg)
        else $error("request stalled with no transaction in flight");

    a_fwd_same_bin: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && req_accept && (p1_addr == rd_addr) |=> fwd_hit_reg)
        else $error("write-back to the bin just read was not forwarded");

    a_clear_max: assert property (@(posedge clk) disable iff (!rst_n)
        p1_go && (p1_data_reg.mode == MODE_CLEAR) |=> maxp_reg == '0)
        else $error("clear did not reset the tracked maximum");

    a_err_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_data_reg.status != STAT_OK) |-> rsp_data_reg.bin_sum == '0)
        else $error("error response carries a nonzero bin sum");

    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(maxp_reg) <= 32'(NUM_BINS))
        else $error("tracked maximum beyond bin count");

endmodule
